// ===== rtl/dtt_pkg.sv =====
package dtt_pkg;

  // Grid size; new_dirty_rows is GRID_ROWS bits wide (ROWS_W).
  localparam int GRID_COLUMNS = 22;
  localparam int GRID_ROWS    = 17;

  localparam int TILE_WIDTH_DEF  = 32;
  localparam int TILE_HEIGHT_DEF = 32;

  localparam int REQ_W    = 2;
  localparam int RECT_W   = 12;
  localparam int SCROLL_W = 5;
  localparam int COL_W    = 5;
  localparam int ROW_W    = 5;
  localparam int ROWS_W   = GRID_ROWS;

  localparam int CIDX_W = $clog2(GRID_COLUMNS);
  localparam int RIDX_W = $clog2(GRID_ROWS);
  localparam int IDX_W  = (CIDX_W > RIDX_W) ? CIDX_W : RIDX_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_MARK  = 2'd0,
    REQ_SWAP  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef enum logic {
    CFG_SCROLL_X = 1'b0,
    CFG_SCROLL_Y = 1'b1
  } cfg_reg_e;

endpackage

// ===== rtl/dtt_if.sv =====
interface dtt_req_if import dtt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [RECT_W-1:0] rect_left;
  logic signed [RECT_W-1:0] rect_top;
  logic signed [RECT_W-1:0] rect_width;
  logic signed [RECT_W-1:0] rect_height;
  logic [COL_W-1:0]         query_column;
  logic [ROW_W-1:0]         query_row;

  modport source (
    output valid, req_type, rect_left, rect_top, rect_width, rect_height,
           query_column, query_row,
    input  ready
  );
  modport sink (
    input  valid, req_type, rect_left, rect_top, rect_width, rect_height,
           query_column, query_row,
    output ready
  );
endinterface

interface dtt_res_if import dtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  tile_column;
  logic [ROWS_W-1:0] new_dirty_rows;
  logic              prev_dirty;
  logic              last_result;

  modport source (
    output valid, tile_column, new_dirty_rows, prev_dirty, last_result,
    input  ready
  );
  modport sink (
    input  valid, tile_column, new_dirty_rows, prev_dirty, last_result,
    output ready
  );
endinterface

// ===== rtl/dtt_ram.sv =====
module dtt_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 22
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/dirty_tile_tracker.sv =====
// Dirty tile tracker over a 22 x 17 grid of screen tiles.
// req_i takes one request word: mark a pixel rectangle, end of frame, or
// query one tile's previous-frame mark. res_o returns result words; the last
// word of a request carries last_result. Scroll offsets are written over the
// APB port (0x0 fine_scroll_x, 0x4 fine_scroll_y); the user must write them
// only while the block is idle, which the block itself does not enforce.
// One request is worked at a time; req_i is ready only when the controller
// is idle, but a finished word may still sit in the output register.
// Mark: the four tile bounds come from one shared reciprocal multiplier in
// turn, then the range check, then one read-modify-write of the current
// bitmap per column through a registered-read RAM, one word per cycle while
// res_o does not stall. End of frame swaps the roles of the two bitmap banks
// and clears the new current bank through per-entry valid bits; its word is
// loaded from S_DONE. A query reads the previous bank on accept; its word is
// loaded from S_QRY. Reset: current marks all zero, previous marks all one,
// offsets zero; there is no clearing pass. When res_o stalls, the column pipe
// holds with the RAM read data parked, and nothing is dropped.
module dirty_tile_tracker import dtt_pkg::*; #(
  parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
  parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dtt_req_if.sink               req_i,
  dtt_res_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SUM_W  = RECT_W + 2;
  localparam int LIM_XI = GRID_COLUMNS * TILE_WIDTH;
  localparam int LIM_YI = GRID_ROWS * TILE_HEIGHT;
  localparam int NDIV   = $clog2((LIM_XI > LIM_YI) ? LIM_XI : LIM_YI);
  localparam int LX     = $clog2(TILE_WIDTH);
  localparam int LY     = $clog2(TILE_HEIGHT);
  localparam int SH_X   = NDIV + LX;
  localparam int SH_Y   = NDIV + LY;
  localparam int MW     = NDIV + 2;
  localparam int PW     = NDIV + MW;
  localparam logic [MW-1:0] M_X = MW'(((1 << SH_X) + TILE_WIDTH - 1) / TILE_WIDTH);
  localparam logic [MW-1:0] M_Y = MW'(((1 << SH_Y) + TILE_HEIGHT - 1) / TILE_HEIGHT);
  localparam logic signed [SUM_W-1:0] LIM_X = SUM_W'(LIM_XI);
  localparam logic signed [SUM_W-1:0] LIM_Y = SUM_W'(LIM_YI);
  localparam logic [IDX_W-1:0] HI_X = IDX_W'(GRID_COLUMNS - 1);
  localparam logic [IDX_W-1:0] HI_Y = IDX_W'(GRID_ROWS - 1);
  localparam int WRAP_X = ((1 << SCROLL_W) - 1) / TILE_WIDTH;
  localparam int WRAP_Y = ((1 << SCROLL_W) - 1) / TILE_HEIGHT;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHK,
    S_MARK,
    S_QRY,
    S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [SCROLL_W-1:0] fine_x_q, fine_y_q;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;

  // request datapath
  logic [SCROLL_W-1:0]     fx, fy;
  logic signed [SUM_W-1:0] sum_q [4];
  logic [1:0]              div_k_q;
  logic [IDX_W-1:0]        bound_q [4];   // sx, sy, ex, ey
  logic signed [SUM_W-1:0] div_v;
  logic                    div_y;
  logic [PW-1:0]           div_prod;
  logic [IDX_W-1:0]        div_q;
  logic [ROWS_W-1:0]       span_d, span_q;
  logic                    range_empty;
  logic [CIDX_W-1:0]       ex_col;

  // column pipe
  logic [CIDX_W-1:0] rd_col_q, s1_col_q;
  logic              rd_more_q, s1_v_q;
  logic              rd_issue, s1_go;

  // query
  logic [CIDX_W-1:0] qc_q;
  logic [RIDX_W-1:0] qr_q;
  logic              qin_d, qin_q, q_issue, q_ans;

  // bitmap banks: sel_q names the current bank, the other one is previous
  logic                    sel_q, prv;
  logic                    ones_q;
  logic [GRID_COLUMNS-1:0] vld_q [2];
  logic                    bank_we [2];
  logic                    bank_re [2];
  logic [CIDX_W-1:0]       bank_raddr [2];
  logic [ROWS_W-1:0]       bank_rdata [2];
  logic [ROWS_W-1:0]       cur_word, prev_word, fresh;

  // output register
  logic              out_v_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROWS_W-1:0] out_rows_q;
  logic              out_prev_q, out_last_q;
  logic              out_free, acc, out_load;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      CFG_SCROLL_X: prdata = CFG_DATA_W'(fine_x_q);
      CFG_SCROLL_Y: prdata = CFG_DATA_W'(fine_y_q);
      default:      prdata = '0;
    endcase
  end

  // fine scroll modulo tile size, WRAP_X / WRAP_Y conditional subtracts
  always_comb begin
    fx = fine_x_q;
    for (int i = 0; i < WRAP_X; i++) begin
      if (fx >= TILE_WIDTH) fx = fx - SCROLL_W'(TILE_WIDTH);
    end
    fy = fine_y_q;
    for (int i = 0; i < WRAP_Y; i++) begin
      if (fy >= TILE_HEIGHT) fy = fy - SCROLL_W'(TILE_HEIGHT);
    end
  end

  // ---------------------------------------------------------------- control
  assign acc      = req_i.valid && req_i.ready;
  assign out_free = !out_v_q || res_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign qin_d   = (req_i.query_column < COL_W'(GRID_COLUMNS)) &&
                   (req_i.query_row < ROW_W'(GRID_ROWS));
  assign q_issue = acc && (req_i.req_type == REQ_QUERY) && qin_d;

  assign ex_col   = bound_q[2][CIDX_W-1:0];
  assign s1_go    = (state_q == S_MARK) && s1_v_q && out_free;
  assign rd_issue = (state_q == S_MARK) && rd_more_q && (!s1_v_q || s1_go);

  // a new word enters the output register this cycle
  assign out_load = s1_go || (((state_q == S_QRY) || (state_q == S_DONE)) && out_free);

  // bound unit: floor division by the tile size via reciprocal multiply,
  // exact for operands below 2**NDIV; the clamps cover everything else
  always_comb begin
    div_v    = sum_q[div_k_q];
    div_y    = div_k_q[0];
    div_prod = PW'(div_v[NDIV-1:0]) * PW'(div_y ? M_Y : M_X);
    if (div_v < 0) begin
      div_q = '0;
    end else if (div_v >= (div_y ? LIM_Y : LIM_X)) begin
      div_q = div_y ? HI_Y : HI_X;
    end else begin
      div_q = div_y ? IDX_W'(div_prod >> SH_Y) : IDX_W'(div_prod >> SH_X);
    end
  end

  assign range_empty = (bound_q[2] < bound_q[0]) || (bound_q[3] < bound_q[1]);

  always_comb begin
    for (int r = 0; r < ROWS_W; r++) begin
      span_d[r] = (IDX_W'(r) >= bound_q[1]) && (IDX_W'(r) <= bound_q[3]);
    end
  end

  // ---------------------------------------------------------------- banks
  assign prv       = ~sel_q;
  assign cur_word  = vld_q[sel_q][s1_col_q] ? bank_rdata[sel_q] : '0;
  assign fresh     = span_q & ~cur_word;
  assign prev_word = vld_q[prv][qc_q] ? bank_rdata[prv] : (ones_q ? '1 : '0);
  assign q_ans     = qin_q && prev_word[qr_q];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    assign bank_we[b]    = (sel_q == 1'(b)) && s1_go;
    assign bank_re[b]    = (sel_q == 1'(b)) ? rd_issue : q_issue;
    assign bank_raddr[b] = (sel_q == 1'(b)) ? rd_col_q :
                                              req_i.query_column[CIDX_W-1:0];

    dtt_ram #(
      .WIDTH (ROWS_W),
      .DEPTH (GRID_COLUMNS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (s1_col_q),
      .wdata_i (cur_word | span_q),
      .re_i    (bank_re[b]),
      .raddr_i (bank_raddr[b]),
      .rdata_o (bank_rdata[b])
    );
  end

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fine_x_q   <= '0;
      fine_y_q   <= '0;
      div_k_q    <= '0;
      rd_more_q  <= 1'b0;
      s1_v_q     <= 1'b0;
      sel_q      <= 1'b0;
      ones_q     <= 1'b1;
      vld_q[0]   <= '0;
      vld_q[1]   <= '0;
      out_v_q    <= 1'b0;
      out_col_q  <= '0;
      out_rows_q <= '0;
      out_prev_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SCROLL_X: fine_x_q <= pwdata[SCROLL_W-1:0];
          CFG_SCROLL_Y: fine_y_q <= pwdata[SCROLL_W-1:0];
          default: ;
        endcase
      end

      if (out_v_q && res_o.ready && !out_load) out_v_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (acc) begin
            case (req_i.req_type)
              REQ_MARK: begin
                div_k_q <= '0;
                state_q <= S_DIV;
              end
              REQ_SWAP: begin
                vld_q[prv] <= '0;
                sel_q      <= prv;
                ones_q     <= 1'b0;
                state_q    <= S_DONE;
              end
              REQ_QUERY: state_q <= S_QRY;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          div_k_q <= div_k_q + 2'd1;
          if (div_k_q == 2'd3) state_q <= S_CHK;
        end
        S_CHK: begin
          if (range_empty) begin
            state_q <= S_DONE;
          end else begin
            rd_more_q <= 1'b1;
            s1_v_q    <= 1'b0;
            state_q   <= S_MARK;
          end
        end
        S_MARK: begin
          if (rd_issue) rd_more_q <= (rd_col_q != ex_col);
          if (rd_issue) begin
            s1_v_q <= 1'b1;
          end else if (s1_go) begin
            s1_v_q <= 1'b0;
          end
          if (s1_go) begin
            vld_q[sel_q][s1_col_q] <= 1'b1;
            out_v_q    <= 1'b1;
            out_col_q  <= COL_W'(s1_col_q);
            out_rows_q <= fresh;
            out_prev_q <= 1'b0;
            out_last_q <= (s1_col_q == ex_col);
            if (s1_col_q == ex_col) state_q <= S_IDLE;
          end
        end
        S_QRY: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_col_q  <= '0;
            out_rows_q <= '0;
            out_prev_q <= q_ans;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_col_q  <= '0;
            out_rows_q <= '0;
            out_prev_q <= 1'b0;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (acc) begin
      sum_q[0] <= SUM_W'(req_i.rect_left) + $signed(SUM_W'(fx));
      sum_q[1] <= SUM_W'(req_i.rect_top) + $signed(SUM_W'(fy));
      sum_q[2] <= SUM_W'(req_i.rect_left) + SUM_W'(req_i.rect_width) +
                  $signed(SUM_W'(fx));
      sum_q[3] <= SUM_W'(req_i.rect_top) + SUM_W'(req_i.rect_height) +
                  $signed(SUM_W'(fy));
      qc_q  <= req_i.query_column[CIDX_W-1:0];
      qr_q  <= req_i.query_row[RIDX_W-1:0];
      qin_q <= qin_d;
    end
    if (state_q == S_DIV) bound_q[div_k_q] <= div_q;
    if (state_q == S_CHK) begin
      span_q   <= span_d;
      rd_col_q <= bound_q[0][CIDX_W-1:0];
    end
    if (rd_issue) begin
      rd_col_q <= rd_col_q + 1'b1;
      s1_col_q <= rd_col_q;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.tile_column    = out_col_q;
  assign res_o.new_dirty_rows = out_rows_q;
  assign res_o.prev_dirty     = out_prev_q;
  assign res_o.last_result    = out_last_q;

  // ---------------------------------------------------------------- checks
  a_s1_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK && s1_v_q) |->
      (s1_col_q >= bound_q[0][CIDX_W-1:0] && s1_col_q <= ex_col))
    else $error("column pipe left the tile range");

  a_no_rmw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_issue && s1_go) |-> (rd_col_q != s1_col_q))
    else $error("read and write-back hit the same column");

  a_swap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_i.req_type == REQ_SWAP) |=>
      (vld_q[sel_q] == '0 && sel_q != $past(sel_q) && !ones_q))
    else $error("frame swap left stale marks in the current bank");

  a_sel_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc && req_i.req_type == REQ_SWAP) |=> $stable(sel_q))
    else $error("bank select moved without a frame swap");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!s1_v_q && !rd_more_q))
    else $error("column pipe busy while idle");

endmodule
